// File: design/socf_pkg.sv
package socf_pkg;

    // Sizes of the row buffer and the row counter.
    localparam int MAX_ROW_ENTRIES = 16;
    localparam int INDEX_BITS      = 20;
    localparam int ADDR_W          = $clog2(MAX_ROW_ENTRIES);
    localparam int CNT_W           = $clog2(MAX_ROW_ENTRIES + 1);

    // Field widths.
    localparam int COL_W   = 20;
    localparam int VAL_W   = 32;
    localparam int NEG_W   = VAL_W + 1;
    localparam int ROW_W   = 20;
    localparam int TOTAL_W = 24;
    localparam int THETA_W = 17;
    localparam int THR_W   = THETA_W + 1 + NEG_W;
    localparam int FRAC_W  = 16;

    localparam logic [THETA_W-1:0] THETA_RESET = THETA_W'(16384);
    localparam logic [TOTAL_W-1:0] COUNT_MAX   = {TOTAL_W{1'b1}};

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = ((COL_W + VAL_W + 7) / 8) * 8;
    localparam int M_USED_W  = COL_W + ROW_W + TOTAL_W + 1;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // Depth of the row descriptor queue, one per buffer bank.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Write into the row buffer, from the front to the back.
    typedef struct packed {
        logic              we;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  col;
        logic [VAL_W-1:0]  val;
    } buf_wr_t;

    // One finished row waiting for replay.
    typedef struct packed {
        logic                    bank;
        logic [CNT_W-1:0]        count;
        logic signed [NEG_W-1:0] max_neg;
        logic [ROW_W-1:0]        row;
        logic                    ovf;
    } row_desc_t;

    // The back hands a bank back to the front.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_READ,
        BK_TEST,
        BK_END
    } back_state_t;

endpackage

// File: design/socf_queue.sv
module socf_queue
    import socf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  row_desc_t push_desc,
    output logic      push_ready,
    input  logic      pop,
    output row_desc_t pop_desc,
    output logic      pop_valid
);

    row_desc_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_desc   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Descriptor storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("descriptor queue count out of range");

endmodule

// File: design/socf_front.sv
module socf_front
    import socf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output buf_wr_t              buf_wr,
    output logic                 push,
    output row_desc_t            push_desc,
    input  logic                 push_ready,
    input  bank_rel_t            bank_rel
);

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [NEG_W-1:0] max_reg, max_next;
    logic                    ovf_reg, ovf_next;
    logic [INDEX_BITS-1:0]   row_reg, row_next;
    logic                    bank_reg, bank_next;
    logic [1:0]              busy_reg, busy_next;

    logic                    accept, first, store;
    logic [COL_W-1:0]        in_col;
    logic [VAL_W-1:0]        in_val;
    logic signed [NEG_W-1:0] in_neg, max_upd;
    logic [CNT_W-1:0]        cnt_upd;
    logic                    ovf_upd;

    // A word is taken only while its bank is free of an unfinished row.
    assign s_tready = !busy_reg[bank_reg] && push_ready;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && s_tlast;

    assign in_col = s_tdata[COL_W-1:0];
    assign in_val = s_tdata[COL_W+VAL_W-1:COL_W];
    assign in_neg = -$signed({in_val[VAL_W-1], in_val});

    // Running maximum of the negated values; the first word of a row seeds it.
    assign first   = cnt_reg == '0;
    assign max_upd = (first || (in_neg > max_reg)) ? in_neg : max_reg;
    assign store   = cnt_reg < CNT_W'(MAX_ROW_ENTRIES);
    assign cnt_upd = store ? cnt_reg + 1'b1 : cnt_reg;
    assign ovf_upd = ovf_reg || !store;

    // Buffer write for words that still fit.
    assign buf_wr.we   = accept && store;
    assign buf_wr.bank = bank_reg;
    assign buf_wr.addr = cnt_reg[ADDR_W-1:0];
    assign buf_wr.col  = in_col;
    assign buf_wr.val  = in_val;

    // Row summary handed to the back at row end.
    assign push_desc.bank    = bank_reg;
    assign push_desc.count   = cnt_upd;
    assign push_desc.max_neg = max_upd;
    assign push_desc.row     = ROW_W'(row_reg);
    assign push_desc.ovf     = ovf_upd;

    // Row state and bank ownership.
    always_comb begin
        cnt_next  = cnt_reg;
        max_next  = max_reg;
        ovf_next  = ovf_reg;
        row_next  = row_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (bank_rel.valid) begin
            busy_next[bank_rel.bank] = 1'b0;
        end
        if (accept) begin
            if (s_tlast) begin
                cnt_next  = '0;
                max_next  = '0;
                ovf_next  = 1'b0;
                row_next  = row_reg + 1'b1;
                bank_next = !bank_reg;
                busy_next[bank_reg] = 1'b1;
            end else begin
                cnt_next = cnt_upd;
                max_next = max_upd;
                ovf_next = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            max_reg  <= '0;
            ovf_reg  <= 1'b0;
            row_reg  <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            max_reg  <= max_next;
            ovf_reg  <= ovf_next;
            row_reg  <= row_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_wr.we |-> !busy_reg[buf_wr.bank])
        else $error("row buffer write into a bank under replay");

    a_release_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        bank_rel.valid |-> busy_reg[bank_rel.bank])
        else $error("bank released that was not held");

endmodule

// File: design/socf_back.sv
module socf_back
    import socf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [THETA_W-1:0]   cfg_wr_data,
    input  buf_wr_t              buf_wr,
    input  logic                 q_valid,
    input  row_desc_t            q_desc,
    output logic                 q_pop,
    output bank_rel_t            bank_rel,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int MEM_DEPTH = 2 * MAX_ROW_ENTRIES;

    back_state_t             state_reg, state_next;
    row_desc_t               desc_reg;
    logic [THETA_W-1:0]      theta_reg;
    logic signed [THR_W-1:0] thr_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [TOTAL_W-1:0]      total_reg, total_next;

    logic [COL_W-1:0]        col_mem [MEM_DEPTH];
    logic [VAL_W-1:0]        val_mem [MEM_DEPTH];
    logic [COL_W-1:0]        rd_col_reg;
    logic [VAL_W-1:0]        rd_val_reg;

    logic                    m_valid_reg;
    logic                    m_last_reg;
    logic [COL_W-1:0]        m_col_reg;
    logic [ROW_W-1:0]        m_row_reg;
    logic [TOTAL_W-1:0]      m_total_reg;
    logic                    m_ovf_reg;

    logic                    out_free, thr_pos, more, entry_strong;
    logic                    rd_en, idx_inc, load_strong, load_end;
    logic signed [NEG_W-1:0] rd_neg;
    logic signed [THR_W-1:0] rd_scaled;
    logic signed [THR_W-1:0] product;

    // Threshold times 65536, exact.
    assign product = $signed({1'b0, theta_reg}) * desc_reg.max_neg;
    assign thr_pos = thr_reg > 0;
    assign more    = idx_reg < desc_reg.count;

    // Strength test of the buffered word just read.
    assign rd_neg       = -$signed({rd_val_reg[VAL_W-1], rd_val_reg});
    assign rd_scaled    = THR_W'(rd_neg) <<< FRAC_W;
    assign entry_strong = rd_scaled >= thr_reg;

    assign out_free = !m_valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) state_next = BK_MUL;
            end
            BK_MUL: begin
                state_next = BK_READ;
            end
            BK_READ: begin
                state_next = (thr_pos && more) ? BK_TEST : BK_END;
            end
            BK_TEST: begin
                if (!entry_strong || out_free) state_next = BK_READ;
            end
            BK_END: begin
                if (out_free) state_next = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs of the replay sequencer.
    always_comb begin
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        idx_inc     = 1'b0;
        load_strong = 1'b0;
        load_end    = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                q_pop = q_valid;
            end
            BK_READ: begin
                rd_en = thr_pos && more;
            end
            BK_TEST: begin
                if (!entry_strong) begin
                    idx_inc = 1'b1;
                end else if (out_free) begin
                    idx_inc     = 1'b1;
                    load_strong = 1'b1;
                end
            end
            BK_END: begin
                load_end = out_free;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign bank_rel.valid = load_end;
    assign bank_rel.bank  = desc_reg.bank;

    // Saturating strong count.
    always_comb begin
        total_next = total_reg;
        if (load_strong && (total_reg != COUNT_MAX)) begin
            total_next = total_reg + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            theta_reg   <= THETA_RESET;
            total_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (cfg_wr_en) begin
                theta_reg <= cfg_wr_data;
            end
            if (q_pop) begin
                idx_reg <= '0;
            end else if (idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load_strong || load_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Row descriptor, threshold and output word.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            desc_reg <= q_desc;
        end
        if (state_reg == BK_MUL) begin
            thr_reg <= product;
        end
        if (load_strong) begin
            m_last_reg  <= 1'b0;
            m_col_reg   <= rd_col_reg;
            m_row_reg   <= desc_reg.row;
            m_total_reg <= total_next;
            m_ovf_reg   <= 1'b0;
        end else if (load_end) begin
            m_last_reg  <= 1'b1;
            m_col_reg   <= '0;
            m_row_reg   <= desc_reg.row;
            m_total_reg <= total_reg;
            m_ovf_reg   <= desc_reg.ovf;
        end
    end

    // Two-bank row buffer: the front fills one bank while the other replays.
    always_ff @(posedge aclk) begin
        if (buf_wr.we) begin
            col_mem[{buf_wr.bank, buf_wr.addr}] <= buf_wr.col;
            val_mem[{buf_wr.bank, buf_wr.addr}] <= buf_wr.val;
        end
        if (rd_en) begin
            rd_col_reg <= col_mem[{desc_reg.bank, idx_reg[ADDR_W-1:0]}];
            rd_val_reg <= val_mem[{desc_reg.bank, idx_reg[ADDR_W-1:0]}];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}},
                       m_ovf_reg, m_total_reg, m_row_reg, m_col_reg};

    a_test_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_TEST) |-> ($past(state_reg) == BK_READ || $past(state_reg) == BK_TEST))
        else $error("strength test without a buffer read");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != BK_IDLE && state_reg != BK_MUL) |-> idx_reg <= desc_reg.count)
        else $error("replay index past the row length");

    a_total_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> total_reg >= $past(total_reg))
        else $error("strong count went backward");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_strong || load_end) && m_valid_reg |-> m_tready)
        else $error("output word overwritten before it was taken");

endmodule

// File: design/strength_of_connection_filter.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata = column, entry_value; tlast = row_done
// m_        out  m_tvalid/m_tready  tdata = strong_column, row_number, strong_count,
//                                   overflow; tlast = is_row_end
// cfg_      in   cfg_wr_en          cfg_wr_data = theta
//
// Entry words are taken one per cycle into one bank of a two-bank row buffer.
// Each row is then replayed by the back end: a setup per row (queue pop, threshold
// multiply), then a buffer read and a test per buffered entry, then the row-end word.
// The replay of one row overlaps the arrival of the next; the input stalls only
// when the bank it would fill still holds a row not yet replayed. A stalled output
// holds up the replay and so, in time, the input.
// Reset is synchronous, active low; it sets theta to 16384 and clears all counts.
module strength_of_connection_filter
    import socf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [THETA_W-1:0]   cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // column [19:0], entry_value [51:20], zero pad
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // strong_column [19:0], row_number [39:20],
                                            // strong_count [63:40], overflow [64], zero pad
    output logic                 m_tlast
);

    buf_wr_t   buf_wr;
    logic      push, push_ready, q_pop, q_valid;
    row_desc_t push_desc, q_desc;
    bank_rel_t bank_rel;

    socf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .buf_wr     (buf_wr),
        .push       (push),
        .push_desc  (push_desc),
        .push_ready (push_ready),
        .bank_rel   (bank_rel)
    );

    socf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_desc  (push_desc),
        .push_ready (push_ready),
        .pop        (q_pop),
        .pop_desc   (q_desc),
        .pop_valid  (q_valid)
    );

    socf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .buf_wr      (buf_wr),
        .q_valid     (q_valid),
        .q_desc      (q_desc),
        .q_pop       (q_pop),
        .bank_rel    (bank_rel),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// File: sim/tb_strength_of_connection_filter.sv
`timescale 1ns / 1ps

module tb_strength_of_connection_filter;
    import socf_pkg::*;

    localparam int  CYCLE_LIMIT      = 1000000;
    localparam int  SETTLE_CYCLES    = 40;
    localparam int  ITEMS_PER_PHASE  = 36;
    localparam int  FRAC_SCALE       = 65536;

    // One matrix entry as it is sent on the input stream.
    typedef struct packed {
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] value;
        logic                    row_done;
    } entry_t;

    // One record as it should leave the output stream.
    typedef struct {
        logic               is_row_end;
        logic [COL_W-1:0]   strong_column;
        logic [ROW_W-1:0]   row_number;
        logic [TOTAL_W-1:0] strong_count;
        logic               overflow;
    } record_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [THETA_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    strength_of_connection_filter i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Shadow copy of the filter state.
    logic [THETA_W-1:0]    theta_shadow = THETA_RESET;
    logic [COL_W-1:0]      held_columns [MAX_ROW_ENTRIES];
    logic signed [VAL_W-1:0] held_values [MAX_ROW_ENTRIES];
    int                    held_count   = 0;
    longint                row_max_neg  = 0;
    logic [ROW_W-1:0]      shadow_row   = '0;
    logic [TOTAL_W-1:0]    strong_total = '0;
    logic                  row_dropped  = 1'b0;

    entry_t  pending_entries [$];
    record_t expected_records [$];
    entry_t  entry_on_bus;
    int      entries_queued = 0;
    int      entries_taken  = 0;
    int      failures       = 0;
    int      cycle_count    = 0;
    int      send_gap       = 0;
    int      ready_stall    = 0;
    logic    sender_gaps_on   = 1'b1;
    logic    receiver_stalls_on = 1'b1;

    // Clock.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Take one entry into the shadow row and, at row end, queue the records it causes.
    function automatic void filter_entry(entry_t e);
        longint  neg_val;
        longint  thr;
        longint  nv;
        record_t rec;
        neg_val = -longint'(e.value);
        if (held_count == 0 && !row_dropped) begin
            row_max_neg = neg_val;
        end else if (neg_val > row_max_neg) begin
            row_max_neg = neg_val;
        end
        if (held_count < MAX_ROW_ENTRIES) begin
            held_columns[held_count] = e.column;
            held_values[held_count]  = e.value;
            held_count++;
        end else begin
            row_dropped = 1'b1;
        end
        if (!e.row_done) begin
            return;
        end
        // The threshold is kept scaled by 2^16 so the compare is exact.
        thr = longint'(theta_shadow) * row_max_neg;
        if (thr > 0) begin
            for (int i = 0; i < held_count; i++) begin
                nv = -longint'(held_values[i]);
                if (nv * FRAC_SCALE >= thr) begin
                    if (strong_total != COUNT_MAX) begin
                        strong_total++;
                    end
                    rec.is_row_end    = 1'b0;
                    rec.strong_column = held_columns[i];
                    rec.row_number    = shadow_row;
                    rec.strong_count  = strong_total;
                    rec.overflow      = 1'b0;
                    expected_records.insert(expected_records.size(), rec);
                end
            end
        end
        rec.is_row_end    = 1'b1;
        rec.strong_column = '0;
        rec.row_number    = shadow_row;
        rec.strong_count  = strong_total;
        rec.overflow      = row_dropped;
        expected_records.insert(expected_records.size(), rec);
        shadow_row  = shadow_row + 1'b1;
        held_count  = 0;
        row_dropped = 1'b0;
        row_max_neg = 0;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int pick_delay();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return $urandom_range(1, 3);
        end else if (r < 19) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(10, 40);
    endfunction

    // Input driver: presents queued words and feeds the shadow model on acceptance.
    always @(posedge aclk) begin : entry_driver
        logic busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                filter_entry(entry_on_bus);
                entries_taken++;
                busy = 1'b0;
                if (sender_gaps_on && $urandom_range(0, 2) == 0) begin
                    send_gap = pick_delay();
                end
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_entries.size() > 0) begin
                    entry_on_bus = pending_entries.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({entry_on_bus.value, entry_on_bus.column});
                    s_tlast  <= entry_on_bus.row_done;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted word and drives random back-pressure.
    always @(posedge aclk) begin : record_monitor
        record_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_records.size() == 0) begin
                    $display("%0t: unexpected word, actual tdata %h tlast %b",
                             $time, m_tdata, m_tlast);
                    failures++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("is_row_end", want.is_row_end, m_tlast);
                    check_field("strong_column", want.strong_column, m_tdata[19:0]);
                    check_field("row_number", want.row_number, m_tdata[39:20]);
                    check_field("strong_count", want.strong_count, m_tdata[63:40]);
                    check_field("overflow", want.overflow, m_tdata[64]);
                end
            end
            if (ready_stall > 0) begin
                ready_stall--;
                m_tready <= 1'b0;
            end else if (receiver_stalls_on && $urandom_range(0, 3) == 0) begin
                ready_stall = pick_delay() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_entry(logic [COL_W-1:0] col, logic signed [VAL_W-1:0] val,
                               logic done);
        entry_t e;
        e.column   = col;
        e.value    = val;
        e.row_done = done;
        pending_entries.insert(pending_entries.size(), e);
        entries_queued++;
    endtask

    function automatic logic [COL_W-1:0] pick_column();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return COL_W'($urandom_range(0, 20'hFFFFF));
    endfunction

    // Queue one row built around a negative base value, so that entries land on,
    // just off and far from the threshold. Returns the number of entries.
    task automatic queue_random_row(output int len);
        int unsigned base_mag;
        longint      base_val;
        longint      v;
        int          r;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            len = 1;
        end else if (r < 17) begin
            len = $urandom_range(2, MAX_ROW_ENTRIES);
        end else begin
            len = $urandom_range(MAX_ROW_ENTRIES + 1, MAX_ROW_ENTRIES + 4);
        end
        if ($urandom_range(0, 1) == 0) begin
            base_mag = $urandom_range(1, 1000) * 4;
        end else begin
            base_mag = $urandom_range(1, 32'h2000_0000) * 4;
        end
        base_val = -longint'(base_mag);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0, 1: v = base_val;
                2: v = base_val / 2;
                3: v = base_val / 4;
                4, 5: v = -longint'($urandom_range(0, base_mag));
                6: v = longint'($urandom_range(0, 32'h7FFF_FFFF));
                7: v = base_val / 4 + $urandom_range(0, 2) - 1;
                default: v = longint'($signed($urandom));
            endcase
            queue_entry(pick_column(), VAL_W'(v), i == len - 1);
        end
    endtask

    task automatic queue_random_phase();
        int added;
        int len;
        added = 0;
        while (added < ITEMS_PER_PHASE) begin
            queue_random_row(len);
            added += len;
        end
    endtask

    // Wait until every word is taken and every record seen, then let the block settle.
    task automatic drain();
        while (!(entries_taken == entries_queued && expected_records.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_theta(logic [THETA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        theta_shadow = value;
    endtask

    // Stimulus sequence.
    initial begin
        logic [THETA_W-1:0] theta_list [7];
        theta_list = '{17'd0, 17'd65536, 17'd131071, 17'd1, 17'd32768,
                       THETA_W'($urandom_range(2, 131070)), THETA_RESET};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows at the reset theta.
        // Most negative value alone: its own maximum, so it is strong.
        queue_entry(20'h00000, 32'sh8000_0000, 1'b1);
        // Most positive value alone: threshold below zero, row-end only.
        queue_entry(20'hFFFFF, 32'sh7FFF_FFFF, 1'b1);
        // All-zero row: threshold zero, row-end only.
        queue_entry(20'h00001, 32'sh0, 1'b0);
        queue_entry(20'h00002, 32'sh0, 1'b1);
        // Small mixed row.
        queue_entry(20'h00005, -32'sd1, 1'b0);
        queue_entry(20'hAAAAA, 32'sd1, 1'b1);
        // Full buffer plus two dropped entries, the largest of which sets the maximum.
        for (int i = 0; i < MAX_ROW_ENTRIES; i++) begin
            queue_entry(COL_W'(i * 4097), -VAL_W'((i + 1) * 4096), 1'b0);
        end
        queue_entry(20'h55555, -32'sh4000_0000, 1'b0);
        queue_entry(20'h12345, 32'sd5, 1'b1);
        queue_random_phase();
        drain();

        // Random phases across theta settings, idling switched per phase.
        foreach (theta_list[p]) begin
            write_theta(theta_list[p]);
            sender_gaps_on     = $urandom_range(0, 3) != 0;
            receiver_stalls_on = $urandom_range(0, 3) != 0;
            queue_random_phase();
            drain();
        end

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
